>>> sv/fbu_pkg.sv
// ----------------------------------------------------------------------------
// fbu_pkg
// shared types, constants and widths of the flow upsampler
// ----------------------------------------------------------------------------
`default_nettype none

package fbu_pkg;

    // grid and output geometry
    localparam int GRID_SIZE_DEF = 48;
    localparam int PIXELS        = 8;
    localparam int LINES         = 8;
    localparam int LINE_W        = 3;

    // field widths
    localparam int COMP_W   = 8;
    localparam int CORNER_W = 16;
    localparam int ADDR_W   = 21;
    localparam int STRIDE_W = 12;
    localparam int PIXEL_W  = 32;

    // interpolator widths
    localparam int A_W    = 11;     // left edge value, 8 * component
    localparam int DA_W   = 9;      // left edge step per line
    localparam int D_W    = 12;     // right minus left edge
    localparam int DD_W   = 10;     // step of the difference per line
    localparam int FLOW_W = 11;     // interpolated component after the shift
    localparam int CHAN_W = 12;     // colour channel before clamping

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 12'd240;
    localparam logic [7:0]          ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0]          CHAN_MAX     = 8'hFF;
    localparam logic signed [CHAN_W-1:0] CHAN_OFFSET = 12'sd255;

    typedef struct packed {
        logic signed [COMP_W-1:0] flow_x;
        logic signed [COMP_W-1:0] flow_y;
    } t_flow_in;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_0;
        logic [PIXEL_W-1:0] pixel_1;
        logic [PIXEL_W-1:0] pixel_2;
        logic [PIXEL_W-1:0] pixel_3;
        logic [PIXEL_W-1:0] pixel_4;
        logic [PIXEL_W-1:0] pixel_5;
        logic [PIXEL_W-1:0] pixel_6;
        logic [PIXEL_W-1:0] pixel_7;
        logic [ADDR_W-1:0]  word_address;
        logic               last_line;
    } t_line_out;

    // four corners of one grid cell, x in the low byte, y in the high byte
    typedef struct packed {
        logic [CORNER_W-1:0] c0;    // upper left
        logic [CORNER_W-1:0] c1;    // lower left
        logic [CORNER_W-1:0] c2;    // upper right
        logic [CORNER_W-1:0] c3;    // lower right
        logic [ADDR_W-1:0]   base_addr;
    } t_cell;

    // one line of interpolated flow, component 0 is x and 1 is y
    typedef struct packed {
        logic [1:0][PIXELS-1:0][FLOW_W-1:0] flow;
        logic [ADDR_W-1:0]                  word_address;
        logic                               last_line;
    } t_flow_line;

    typedef enum logic [1:0] {
        FETCH_IDLE,
        FETCH_UPPER_RIGHT,
        FETCH_UPPER_LEFT,
        FETCH_READY
    } t_fetch_state;

endpackage

`default_nettype wire

>>> sv/fbu_ram.sv
// ----------------------------------------------------------------------------
// fbu_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module fbu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/fbu_corner_fetch.sv
// ----------------------------------------------------------------------------
// fbu_corner_fetch
// grid position, delay line and previous row ram; gathers the cell corners
// ----------------------------------------------------------------------------
`default_nettype none

module fbu_corner_fetch
    import fbu_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire t_flow_in            i_in_data,
    input  wire logic [STRIDE_W-1:0] i_stride,
    output logic                     o_cell_valid,
    output t_cell                    o_cell,
    input  wire logic                i_cell_take
);

    localparam int COL_W  = $clog2(GRID_SIZE);
    localparam int PROD_W = COL_W + STRIDE_W;

    t_fetch_state r_state;
    t_fetch_state n_state;

    logic [COL_W-1:0]    r_row;
    logic [COL_W-1:0]    r_col;
    logic [COL_W-1:0]    n_row;
    logic [COL_W-1:0]    n_col;
    logic [CORNER_W-1:0] r_delay_first;
    logic [CORNER_W-1:0] r_delay_second;

    logic [COL_W-1:0]    r_f_row;
    logic [COL_W-1:0]    r_f_col;
    logic                r_f_need;
    logic [CORNER_W-1:0] r_c0;
    logic [CORNER_W-1:0] r_c1;
    logic [CORNER_W-1:0] r_c2;
    logic [CORNER_W-1:0] r_c3;
    logic [PROD_W-1:0]   r_prod;
    logic [ADDR_W-1:0]   r_base;

    logic                w_accept;
    logic                w_done;
    logic [COL_W-1:0]    w_waddr;
    logic [COL_W-1:0]    w_raddr;
    logic [CORNER_W-1:0] w_rdata;
    logic [CORNER_W-1:0] w_cur;

    assign w_cur = {i_in_data.flow_y, i_in_data.flow_x};

    // next grid position
    always_comb begin
        n_row = r_row;
        n_col = r_col + 1'b1;
        if (r_col == COL_W'(GRID_SIZE - 1)) begin
            n_col = '0;
            n_row = (r_row == COL_W'(GRID_SIZE - 1)) ? '0 : r_row + 1'b1;
        end
    end

    // the entry two columns back takes the older delayed point
    assign w_waddr = (r_col >= COL_W'(2)) ? r_col - COL_W'(2) : r_col + COL_W'(GRID_SIZE - 2);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            FETCH_IDLE: begin
                if (w_accept) begin
                    n_state = FETCH_UPPER_RIGHT;
                end
            end
            FETCH_UPPER_RIGHT: n_state = FETCH_UPPER_LEFT;
            FETCH_UPPER_LEFT:  n_state = FETCH_READY;
            FETCH_READY: begin
                if (w_accept) begin
                    n_state = FETCH_UPPER_RIGHT;
                end else if (w_done) begin
                    n_state = FETCH_IDLE;
                end
            end
            default: n_state = FETCH_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cell_valid = 1'b0;
        w_done       = 1'b0;
        o_in_stall   = 1'b1;
        w_raddr      = r_col;
        case (r_state)
            FETCH_IDLE: begin
                o_in_stall = 1'b0;
            end
            FETCH_UPPER_RIGHT: begin
                w_raddr = (r_f_col == '0) ? '0 : r_f_col - 1'b1;
            end
            FETCH_UPPER_LEFT: begin
                o_in_stall = 1'b1;
            end
            FETCH_READY: begin
                o_cell_valid = r_f_need;
                w_done       = !r_f_need || i_cell_take;
                o_in_stall   = !w_done;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign w_accept = i_in_valid && !o_in_stall;

    fbu_ram #(
        .WIDTH (CORNER_W),
        .DEPTH (GRID_SIZE)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (w_waddr),
        .i_wdata (r_delay_first),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= FETCH_IDLE;
            r_row          <= '0;
            r_col          <= '0;
            r_delay_first  <= '0;
            r_delay_second <= '0;
            r_f_need       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_row          <= n_row;
                r_col          <= n_col;
                r_delay_first  <= r_delay_second;
                r_delay_second <= w_cur;
                r_f_need       <= (r_row != '0) && (r_col != '0);
            end
        end
    end

    // cell payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_f_row <= r_row;
            r_f_col <= r_col;
            r_c1    <= r_delay_second;
            r_c3    <= w_cur;
        end
        if (r_state == FETCH_UPPER_RIGHT) begin
            r_c2   <= w_rdata;
            r_prod <= PROD_W'(r_f_row - 1'b1) * PROD_W'(i_stride);
        end
        if (r_state == FETCH_UPPER_LEFT) begin
            r_c0   <= w_rdata;
            r_base <= ADDR_W'({r_prod, 3'b000}) + ADDR_W'(r_f_col - 1'b1);
        end
    end

    assign o_cell = '{c0: r_c0, c1: r_c1, c2: r_c2, c3: r_c3, base_addr: r_base};

    a_no_accept_mid_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FETCH_UPPER_RIGHT || r_state == FETCH_UPPER_LEFT) |-> !w_accept)
        else $error("beat accepted while the corner reads are in flight");

    a_fetch_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FETCH_UPPER_LEFT) |-> $past(r_state) == FETCH_UPPER_RIGHT)
        else $error("upper left read without the upper right read before it");

endmodule

`default_nettype wire

>>> sv/fbu_line_gen.sv
// ----------------------------------------------------------------------------
// fbu_line_gen
// walks the eight lines of a cell, one line of interpolated flow per cycle while i_adv is high
// ----------------------------------------------------------------------------
`default_nettype none

module fbu_line_gen
    import fbu_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_adv,
    input  wire logic [STRIDE_W-1:0] i_stride,
    input  wire logic                i_cell_valid,
    input  wire t_cell               i_cell,
    output logic                     o_cell_take,
    output logic                     o_s_valid,
    output t_flow_line               o_s_line
);

    localparam int PROD_W = D_W + 4;

    logic              r_busy;
    logic [LINE_W-1:0] r_line;
    logic [ADDR_W-1:0] r_addr;

    // left edge, its line step, right minus left and its line step
    logic signed [A_W-1:0]  r_a  [2];
    logic signed [DA_W-1:0] r_da [2];
    logic signed [D_W-1:0]  r_d  [2];
    logic signed [DD_W-1:0] r_dd [2];

    logic signed [A_W-1:0]  n_a  [2];
    logic signed [DA_W-1:0] n_da [2];
    logic signed [D_W-1:0]  n_d  [2];
    logic signed [DD_W-1:0] n_dd [2];

    logic       r_s_valid;
    t_flow_line r_s_line;
    t_flow_line n_s_line;

    logic w_line_end;

    assign w_line_end  = (r_line == LINE_W'(LINES - 1));
    assign o_cell_take = i_cell_valid && (!r_busy || (i_adv && w_line_end));

    // start values of a new cell
    always_comb begin
        logic signed [COMP_W-1:0] c0v;
        logic signed [COMP_W-1:0] c1v;
        logic signed [COMP_W-1:0] c2v;
        logic signed [COMP_W-1:0] c3v;
        for (int k = 0; k < 2; k++) begin
            c0v = signed'(i_cell.c0[8*k +: 8]);
            c1v = signed'(i_cell.c1[8*k +: 8]);
            c2v = signed'(i_cell.c2[8*k +: 8]);
            c3v = signed'(i_cell.c3[8*k +: 8]);
            n_a[1'(k)]  = {c0v, 3'b000};
            n_da[1'(k)] = DA_W'(c1v) - DA_W'(c0v);
            n_d[1'(k)]  = {DA_W'(c2v) - DA_W'(c0v), 3'b000};
            n_dd[1'(k)] = DD_W'(c3v) - DD_W'(c2v) - DD_W'(c1v) + DD_W'(c0v);
        end
    end

    // pixel p of the line: left edge plus p/8 of the difference, floored
    always_comb begin
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] shifted;
        n_s_line = '0;
        for (int k = 0; k < 2; k++) begin
            for (int p = 0; p < PIXELS; p++) begin
                prod    = PROD_W'(r_d[1'(k)]) * PROD_W'(signed'(4'(p)));
                shifted = prod >>> 3;
                n_s_line.flow[1'(k)][LINE_W'(p)] = r_a[1'(k)] + shifted[FLOW_W-1:0];
            end
        end
        n_s_line.word_address = r_addr;
        n_s_line.last_line    = w_line_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_line    <= '0;
            r_s_valid <= 1'b0;
        end else begin
            if (i_adv) begin
                r_s_valid <= r_busy;
            end
            if (o_cell_take) begin
                r_busy <= 1'b1;
                r_line <= '0;
            end else if (i_adv && r_busy) begin
                r_line <= r_line + 1'b1;
                if (w_line_end) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s_line <= n_s_line;
        end
        if (o_cell_take) begin
            r_addr <= i_cell.base_addr;
            for (int k = 0; k < 2; k++) begin
                r_a[1'(k)]  <= n_a[1'(k)];
                r_da[1'(k)] <= n_da[1'(k)];
                r_d[1'(k)]  <= n_d[1'(k)];
                r_dd[1'(k)] <= n_dd[1'(k)];
            end
        end else if (i_adv && r_busy) begin
            r_addr <= r_addr + ADDR_W'(i_stride);
            for (int k = 0; k < 2; k++) begin
                r_a[1'(k)] <= r_a[1'(k)] + A_W'(r_da[1'(k)]);
                r_d[1'(k)] <= r_d[1'(k)] + D_W'(r_dd[1'(k)]);
            end
        end
    end

    assign o_s_valid = r_s_valid;
    assign o_s_line  = r_s_line;

    a_line_needs_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_line != '0) |-> r_busy)
        else $error("line counter running without a cell");

    a_address_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && r_busy && !w_line_end) |=>
        (r_addr == ADDR_W'($past(r_addr) + ADDR_W'($past(i_stride)))))
        else $error("line address did not advance by one stride");

endmodule

`default_nettype wire

>>> sv/fbu_colour_out.sv
// ----------------------------------------------------------------------------
// fbu_colour_out
// maps interpolated flow to rgba pixels and holds the output beat
// ----------------------------------------------------------------------------
`default_nettype none

module fbu_colour_out
    import fbu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_adv,
    input  wire logic       i_s_valid,
    input  wire t_flow_line i_s_line,
    output logic            o_out_valid,
    output t_line_out       o_out_data
);

    logic      r_valid;
    t_line_out r_data;
    t_line_out n_data;

    logic [PIXEL_W-1:0] w_pix [PIXELS];

    // above 255 saturates, anything else keeps its low byte
    function automatic logic [7:0] to_channel(input logic signed [CHAN_W-1:0] v);
        return (v > CHAN_OFFSET) ? CHAN_MAX : v[7:0];
    endfunction

    always_comb begin
        logic signed [FLOW_W-1:0] fx;
        logic signed [FLOW_W-1:0] fy;
        logic signed [CHAN_W-1:0] red;
        logic signed [CHAN_W-1:0] green;
        logic signed [CHAN_W-1:0] sum;
        logic signed [CHAN_W-1:0] blue;
        for (int p = 0; p < PIXELS; p++) begin
            fx    = signed'(i_s_line.flow[0][LINE_W'(p)]);
            fy    = signed'(i_s_line.flow[1][LINE_W'(p)]);
            red   = CHAN_W'(fx) + CHAN_OFFSET;
            green = CHAN_W'(fy) + CHAN_OFFSET;
            sum   = CHAN_W'(fx) + CHAN_W'(fy);
            blue  = CHAN_OFFSET - (sum >>> 1);
            w_pix[LINE_W'(p)] = {ALPHA_OPAQUE, to_channel(green), to_channel(blue),
                                 to_channel(red)};
        end
    end

    always_comb begin
        n_data.pixel_0      = w_pix[0];
        n_data.pixel_1      = w_pix[1];
        n_data.pixel_2      = w_pix[2];
        n_data.pixel_3      = w_pix[3];
        n_data.pixel_4      = w_pix[4];
        n_data.pixel_5      = w_pix[5];
        n_data.pixel_6      = w_pix[6];
        n_data.pixel_7      = w_pix[7];
        n_data.word_address = i_s_line.word_address;
        n_data.last_line    = i_s_line.last_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

`default_nettype wire

>>> sv/flow_bilinear_upsample_rgba.sv
// ----------------------------------------------------------------------------
// flow_bilinear_upsample_rgba
// 8x bilinear upsampler of a flow field to rgba lines
// ----------------------------------------------------------------------------
// Flow vectors come in raster order on a GRID_SIZE by GRID_SIZE grid, one
// vector per input beat. Every grid point outside row 0 and column 0 closes a
// cell with the three points above, left and upper left of it, and the block
// sends eight output beats for it: one line of eight rgba pixels each, with
// the destination word address and a last_line flag on the eighth. The line
// generator sends one line per cycle while the output is not stalled, and
// in a steady stream of cells the next vector is taken while the current
// cell is still being emitted. Points on row 0 or column 0 give no beats,
// and the next point waits for the two reads of the corner fetch from the
// previous row ram over a single read port. The first line of a cell passes
// through the fetch states, the line register and the output register. There
// is no clearing pass after reset: the previous row is always written before
// it is used. The stride register is written through i_cfg_we / i_cfg_wdata
// and must only change while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module flow_bilinear_upsample_rgba
    import fbu_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration: line stride in words
    input  wire logic                i_cfg_we,
    input  wire logic [STRIDE_W-1:0] i_cfg_wdata,
    // flow input beats
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire t_flow_in            i_in_data,
    // pixel line beats
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output t_line_out                o_out_data
);

    logic [STRIDE_W-1:0] r_stride;

    logic       w_cell_valid;
    t_cell      w_cell;
    logic       w_cell_take;
    logic       w_s_valid;
    t_flow_line w_s_line;
    logic       w_adv;

    // line stride register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= STRIDE_RESET;
        end else if (i_cfg_we) begin
            r_stride <= i_cfg_wdata;
        end
    end

    // the line pipeline moves as one unless the output beat is held
    assign w_adv = !(o_out_valid && i_out_stall);

    // grid position, delayed points and previous row ram; hands over one cell
    fbu_corner_fetch #(
        .GRID_SIZE (GRID_SIZE)
    ) u_fetch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_stride     (r_stride),
        .o_cell_valid (w_cell_valid),
        .o_cell       (w_cell),
        .i_cell_take  (w_cell_take)
    );

    // eight lines per cell, interpolated flow registered per line
    fbu_line_gen u_line_gen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_stride     (r_stride),
        .i_cell_valid (w_cell_valid),
        .i_cell       (w_cell),
        .o_cell_take  (w_cell_take),
        .o_s_valid    (w_s_valid),
        .o_s_line     (w_s_line)
    );

    // colour mapping and output register
    fbu_colour_out u_colour (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_s_valid   (w_s_valid),
        .i_s_line    (w_s_line),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> sim/flow_bilinear_upsample_rgba_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flow_bilinear_upsample_rgba_tb
// self-checking bench for the 8x flow to rgba upsampler
// ----------------------------------------------------------------------------
// A clocked driver feeds flow beats from a backlog queue and a clocked monitor
// keeps its own model of the line store, the two delay taps and the grid
// position. Every accepted flow beat is run through that model, and the lines
// it yields are queued and compared field by field with the line beats that
// come out. The run covers the first rows of a frame in five phases with
// different line strides, zero and the largest one among them; the first
// phase runs one row longer so that cells also come out under the reset
// stride. Both sides idle and stall at random, except in one phase that runs
// flat out.
// ----------------------------------------------------------------------------

module flow_bilinear_upsample_rgba_tb;
    import fbu_pkg::*;

    localparam int GRID          = GRID_SIZE_DEF;
    localparam int PHASES        = 5;
    localparam int PHASE_FLOWS   = 20;      // 68 + 4 x 20 points, into the fourth row
    localparam int IDLE_PCT      = 38;
    localparam int SETTLE_CYCLES = 16;      // border points still in the fetch
    localparam int QUIET_LIMIT   = 1000;    // cycles with no beat at all

    localparam logic signed [COMP_W-1:0] COMP_MAX   = 8'sd127;
    localparam logic signed [COMP_W-1:0] COMP_MIN   = -8'sd128;
    localparam logic [STRIDE_W-1:0]      STRIDE_MAX = '1;

    // ---- clock, reset and everything driven into the block ----
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [STRIDE_W-1:0] cfg_wdata = '0;
    logic                in_valid  = 1'b0;
    t_flow_in            flow_in   = '0;
    logic                out_stall = 1'b0;

    logic                out_valid;
    logic                in_stall;
    t_line_out           line_out;

    // ---- bench bookkeeping ----
    t_flow_in  flow_backlog [$];        // flow beats not yet offered
    t_line_out pending_lines [$];       // lines predicted but not yet seen
    int        flows_sent  = 0;
    int        flows_taken = 0;
    int        mismatches  = 0;
    int        quiet_cycles = 0;
    logic      in_taken    = 1'b0;      // flow beat taken at the last rising edge
    logic      steady      = 1'b0;      // no idling on either side

    // ---- model state: line store, delay taps, grid position, stride ----
    logic [CORNER_W-1:0] prev_row [GRID];
    logic [CORNER_W-1:0] lag_near;      // the point taken before lag_far
    logic [CORNER_W-1:0] lag_far;       // the point just taken
    int unsigned         grid_row;
    int unsigned         grid_col;
    logic [STRIDE_W-1:0] stride_words;

    flow_bilinear_upsample_rgba DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (flow_in),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (line_out)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // keep the low 12 bits and read them as two's complement
    function automatic int to_s12(input int v);
        logic signed [CHAN_W-1:0] t;
        t = v[CHAN_W-1:0];
        return t;
    endfunction

    // saturate above 255, plain wrap below
    function automatic logic [7:0] clamp_chan(input int v);
        return (v > 255) ? CHAN_MAX : v[7:0];
    endfunction

    // mostly uniform, with a bias towards the two extremes
    function automatic logic [COMP_W-1:0] rand_comp();
        case ($urandom_range(7, 0))
            0: return COMP_MAX;
            1: return COMP_MIN;
            default: return COMP_W'($urandom);
        endcase
    endfunction

    // take one flow point into the model and queue the lines of its cell
    task automatic predict_cell_lines(input t_flow_in beat);
        logic [CORNER_W-1:0]      corner [4];
        logic signed [COMP_W-1:0] cx, cy;
        logic [PIXELS*PIXEL_W-1:0] pix;
        t_line_out                line;
        int unsigned              wr_idx, addr;
        int                       wgt, sum_x, sum_y, fx, fy;

        // the store slot two columns back is free once its point left the taps
        wr_idx = (grid_col < 2) ? grid_col + GRID - 2 : grid_col - 2;
        prev_row[wr_idx] = lag_near;
        lag_near = lag_far;
        lag_far  = {beat.flow_y, beat.flow_x};

        corner[0] = prev_row[(grid_col > 0) ? grid_col - 1 : 0];   // upper left
        corner[1] = lag_near;                                       // lower left
        corner[2] = prev_row[grid_col];                             // upper right
        corner[3] = lag_far;                                        // lower right

        // border points only fill the store and the taps
        if (grid_row > 0 && grid_col > 0) begin
            for (int l = 0; l < LINES; l++) begin
                for (int p = 0; p < PIXELS; p++) begin
                    sum_x = 0;
                    sum_y = 0;
                    for (int k = 0; k < 4; k++) begin
                        // right corners weigh p, lower corners weigh l
                        wgt = ((k >= 2) ? p : 8 - p) * ((k % 2 == 1) ? l : 8 - l);
                        cx = corner[k][7:0];
                        cy = corner[k][15:8];
                        sum_x += wgt * cx;
                        sum_y += wgt * cy;
                    end
                    fx = to_s12(sum_x >>> 3);
                    fy = to_s12(sum_y >>> 3);
                    pix[(PIXELS-1-p)*PIXEL_W +: PIXEL_W] = {
                        ALPHA_OPAQUE,
                        clamp_chan(to_s12(fy + 255)),
                        clamp_chan(to_s12(255 - ((fx + fy) >>> 1))),
                        clamp_chan(to_s12(fx + 255))
                    };
                end
                {line.pixel_0, line.pixel_1, line.pixel_2, line.pixel_3,
                 line.pixel_4, line.pixel_5, line.pixel_6, line.pixel_7} = pix;
                addr = (grid_row - 1) * 8 * stride_words + l * stride_words + grid_col - 1;
                line.word_address = addr[ADDR_W-1:0];
                line.last_line    = (l == LINES - 1);
                pending_lines.push_back(line);
            end
        end

        // raster order, wrapping at the end of a row and of the frame
        grid_col++;
        if (grid_col >= GRID) begin
            grid_col = 0;
            grid_row++;
            if (grid_row >= GRID)
                grid_row = 0;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_line(input t_line_out got);
        t_line_out                 want;
        logic [PIXELS*PIXEL_W-1:0] want_pix, got_pix;

        if (pending_lines.size() == 0) begin
            $error("line beat with nothing predicted, address %0h", got.word_address);
            mismatches++;
        end else begin
            want = pending_lines.pop_front();
            want_pix = {want.pixel_0, want.pixel_1, want.pixel_2, want.pixel_3,
                        want.pixel_4, want.pixel_5, want.pixel_6, want.pixel_7};
            got_pix  = {got.pixel_0, got.pixel_1, got.pixel_2, got.pixel_3,
                        got.pixel_4, got.pixel_5, got.pixel_6, got.pixel_7};
            for (int p = 0; p < PIXELS; p++)
                compare_field($sformatf("pixel_%0d", p),
                              want_pix[(PIXELS-1-p)*PIXEL_W +: PIXEL_W],
                              got_pix[(PIXELS-1-p)*PIXEL_W +: PIXEL_W]);
            compare_field("word_address", want.word_address, got.word_address);
            compare_field("last_line", want.last_line, got.last_line);
        end
    endtask

    // ---- driver: new values at the falling edge ----
    always @(negedge clk) begin
        // a flow beat holds until taken, then the next one may follow
        if (rst_n && (!in_valid || in_taken)) begin
            if (flow_backlog.size() != 0 &&
                (steady || $urandom_range(99, 0) >= IDLE_PCT)) begin
                in_valid <= 1'b1;
                flow_in  <= flow_backlog.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= !steady && ($urandom_range(99, 0) < IDLE_PCT);
    end

    // ---- monitor: everything sampled at the rising edge ----
    always @(posedge clk) begin
        if (!rst_n) begin
            for (int i = 0; i < GRID; i++)
                prev_row[i] = '0;
            lag_near     = '0;
            lag_far      = '0;
            grid_row     = 0;
            grid_col     = 0;
            stride_words = STRIDE_RESET;
            in_taken    <= 1'b0;
        end else begin
            in_taken <= in_valid && !in_stall;
            // outputs first: a line never leaves in the cycle its flow beat enters
            if (out_valid && !out_stall)
                check_line(line_out);
            if (in_valid && !in_stall) begin
                predict_cell_lines(flow_in);
                flows_taken++;
            end
            if (cfg_we)
                stride_words = cfg_wdata;
        end
    end

    // ---- watchdog: too long without a beat on either side ----
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** flow_bilinear_upsample_rgba: FAILED **");
            $finish;
        end
    end

    // ---- stimulus: reset, then phases with their own stride ----
    initial begin
        t_flow_in            probe [12];
        t_flow_in            beat;
        logic [STRIDE_W-1:0] stride_plan [PHASES];
        int unsigned         slot, pos_col;

        // extremes first: runs of equal points give cells that are all
        // maximum or all minimum, the rest mix signs and small values
        probe[0]  = '{COMP_MAX, COMP_MAX};
        probe[1]  = '{COMP_MAX, COMP_MAX};
        probe[2]  = '{COMP_MIN, COMP_MIN};
        probe[3]  = '{COMP_MIN, COMP_MIN};
        probe[4]  = '{COMP_MAX, COMP_MIN};
        probe[5]  = '{COMP_MIN, COMP_MAX};
        probe[6]  = '{8'sd0, 8'sd0};
        probe[7]  = '{-8'sd1, -8'sd1};
        probe[8]  = '{COMP_MAX, 8'sd0};
        probe[9]  = '{8'sd1, -8'sd1};
        probe[10] = '{8'sd64, -8'sd64};
        probe[11] = '{-8'sd65, 8'sd63};

        // phase 0 keeps the reset stride, then zero, largest, one, random
        stride_plan[0] = STRIDE_RESET;
        stride_plan[1] = '0;
        stride_plan[2] = STRIDE_MAX;
        stride_plan[3] = 12'd1;
        stride_plan[4] = STRIDE_W'($urandom_range(4095, 1));
        slot = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            // the block is idle here, so the stride may change
            if (ph > 0) begin
                @(negedge clk);
                cfg_we    <= 1'b1;
                cfg_wdata <= stride_plan[ph];
                @(negedge clk);
                cfg_we    <= 1'b0;
            end
            steady = (ph == 2);

            // row 0 gives no cells, so the first phase runs one row further
            repeat ((ph == 0) ? GRID + PHASE_FLOWS : PHASE_FLOWS) begin
                pos_col = slot % GRID;
                // first two rows of the first frame carry the probe points
                if (slot < 2 * GRID && pos_col >= 1 && pos_col <= 12)
                    beat = probe[pos_col-1];
                else begin
                    beat.flow_x = rand_comp();
                    beat.flow_y = rand_comp();
                end
                flow_backlog.push_back(beat);
                flows_sent++;
                slot++;
            end

            // drain: every flow beat taken and every line seen
            do @(negedge clk);
            while (flows_taken != flows_sent || pending_lines.size() != 0);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end

        if (mismatches == 0 && pending_lines.size() == 0)
            $display("** flow_bilinear_upsample_rgba: PASSED **");
        else
            $display("** flow_bilinear_upsample_rgba: FAILED **");
        $finish;
    end

endmodule
